FILE: sv/trbe_pkg.sv
// ----------------------------------------------------------------------------
// Typed register bytecode execute: shared definitions
// Opcodes, type tags, state codes and field widths.
// ----------------------------------------------------------------------------
package trbe_pkg;

  localparam int NUM_REGS = 32;
  localparam int REG_AW   = 5;
  localparam int VAL_W    = 64;
  localparam int TAG_W    = 4;

  localparam logic [TAG_W-1:0] TAG_S64 = 4'd4;

  localparam logic [5:0] OP_I8     = 6'd1;
  localparam logic [5:0] OP_I16    = 6'd2;
  localparam logic [5:0] OP_I64    = 6'd4;
  localparam logic [5:0] OP_U8     = 6'd6;
  localparam logic [5:0] OP_U16    = 6'd7;
  localparam logic [5:0] OP_U64    = 6'd9;
  localparam logic [5:0] OP_NEG    = 6'd10;
  localparam logic [5:0] OP_POS    = 6'd11;
  localparam logic [5:0] OP_NOT    = 6'd12;
  localparam logic [5:0] OP_INV    = 6'd13;
  localparam logic [5:0] OP_ADD    = 6'd14;
  localparam logic [5:0] OP_SUB    = 6'd15;
  localparam logic [5:0] OP_MUL    = 6'd16;
  localparam logic [5:0] OP_DIV    = 6'd17;
  localparam logic [5:0] OP_MOD    = 6'd18;
  localparam logic [5:0] OP_AND    = 6'd19;
  localparam logic [5:0] OP_OR     = 6'd20;
  localparam logic [5:0] OP_XOR    = 6'd21;
  localparam logic [5:0] OP_SHL    = 6'd22;
  localparam logic [5:0] OP_SHR    = 6'd23;
  localparam logic [5:0] OP_LT     = 6'd24;
  localparam logic [5:0] OP_NE     = 6'd29;
  localparam logic [5:0] OP_JLT    = 6'd30;
  localparam logic [5:0] OP_JGT    = 6'd32;
  localparam logic [5:0] OP_JNE    = 6'd35;
  localparam logic [5:0] OP_MOV    = 6'd36;
  localparam logic [5:0] OP_JMP    = 6'd37;
  localparam logic [5:0] OP_NOP    = 6'd38;
  localparam logic [5:0] OP_END    = 6'd39;

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_READ  = 7'b0000010,
    ST_EXEC  = 7'b0000100,
    ST_MUL   = 7'b0001000,
    ST_DIV   = 7'b0010000,
    ST_DFIX  = 7'b0100000,
    ST_OUT   = 7'b1000000
  } state_t;

  // Compare selector 0..5: lt, le, gt, ge, eq, ne.
  function automatic logic compare_op(input logic [2:0] sel,
                                      input logic [VAL_W-1:0] x,
                                      input logic [VAL_W-1:0] y);
    logic lt_xy;
    logic lt_yx;
    lt_xy = $signed(x) < $signed(y);
    lt_yx = $signed(y) < $signed(x);
    case (sel)
      3'd0:    compare_op = lt_xy;
      3'd1:    compare_op = !lt_yx;
      3'd2:    compare_op = lt_yx;
      3'd3:    compare_op = !lt_xy;
      3'd4:    compare_op = x == y;
      default: compare_op = x != y;
    endcase
  endfunction

endpackage

FILE: sv/typed_register_bytecode_execute.sv
// ----------------------------------------------------------------------------
// Typed register bytecode execute
// Executes one bytecode instruction per input transfer against a register
// file of type tags and 64-bit values.
// ----------------------------------------------------------------------------
// Usage: an instruction enters on the s_axis channel; its single result
// leaves on m_axis. The block handles one instruction at a time and drops
// s_axis_tready until the result transfer has completed.
// Sequence: the register file is a memory with a registered read, so an
// instruction passes through the accept, read and execute states in order
// and then offers its result from the output state. Multiply runs through a
// 32x32 multiplier over three partial products. Divide and modulo run a
// restoring radix-2 divider, one quotient bit a cycle, followed by a sign
// correction step.
// Reset: sequencer returns to idle, and a clearing pass writes zero tag
// and value to every register; tready stays low meanwhile.
// Stall: the result is held stable in the output register until taken.
// ----------------------------------------------------------------------------
module typed_register_bytecode_execute (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // operation[5:0], reg_a[10:6], reg_b[15:11], reg_c[20:16],
  // immediate[84:21], jump_distance[100:85], zero fill to 104
  input  logic [103:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // pc_step[15:0], halted[16], write_enable[17], write_register[22:18],
  // write_type[26:23], write_value[90:27], type_mismatch[91],
  // divide_by_zero[92], zero fill to 96
  output logic [95:0]  m_axis_tdata
);

  localparam int AW = trbe_pkg::REG_AW;
  localparam int VW = trbe_pkg::VAL_W;
  localparam int TW = trbe_pkg::TAG_W;

  // Register file memories.
  logic [TW-1:0] tag_mem [trbe_pkg::NUM_REGS];
  logic [VW-1:0] val_mem [trbe_pkg::NUM_REGS];

  trbe_pkg::state_t state;

  logic [5:0]    op;
  logic [AW-1:0] ra;
  logic [AW-1:0] rb;
  logic [AW-1:0] rc;
  logic [VW-1:0] imm;
  logic [15:0]   jump_dist;

  // Registered read ports: a, b, c.
  logic [TW-1:0] tag_a, tag_b, tag_c;
  logic [VW-1:0] val_a, val_b, val_c;

  logic          clearing;
  logic [AW:0]   clr_cnt;

  // Shared iterative unit registers.
  logic [VW-1:0] rem;
  logic [VW-1:0] quo;
  logic [VW-1:0] dvs;
  logic [6:0]    cnt;
  logic          neg_q;
  logic          neg_r;

  // Result register.
  logic [15:0]   r_step;
  logic          r_halt;
  logic          r_we;
  logic [TW-1:0] r_type;
  logic [VW-1:0] r_val;
  logic          r_mis;
  logic          r_dz;

  // Result computed in the execute cycle.
  logic [15:0]   r_step_next;
  logic          r_halt_next;
  logic          r_we_next;
  logic [TW-1:0] r_type_next;
  logic [VW-1:0] r_val_next;
  logic          r_mis_next;
  logic          r_dz_next;

  // Register file write control.
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [TW-1:0] wr_tag;
  logic [VW-1:0] wr_val;

  assign s_axis_tready = (state == trbe_pkg::ST_IDLE) && !clearing;
  assign m_axis_tvalid = (state == trbe_pkg::ST_OUT);
  assign m_axis_tdata  = {3'b000, r_dz, r_mis, r_val, r_type,
                          (r_we ? ra : {AW{1'b0}}), r_we, r_halt, r_step};

  always_ff @(posedge clk) begin
    tag_a <= tag_mem[ra];
    val_a <= val_mem[ra];
    tag_b <= tag_mem[rb];
    val_b <= val_mem[rb];
    tag_c <= tag_mem[rc];
    val_c <= val_mem[rc];
    if (wr_en) begin
      tag_mem[wr_addr] <= wr_tag;
      val_mem[wr_addr] <= wr_val;
    end
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = ra;
    wr_tag  = r_type;
    wr_val  = r_val;
    if (clearing) begin
      wr_en   = 1'b1;
      wr_addr = clr_cnt[AW-1:0];
      wr_tag  = '0;
      wr_val  = '0;
    end else if (state == trbe_pkg::ST_OUT && m_axis_tready && r_we) begin
      wr_en = 1'b1;
    end
  end

  logic          x_ok, y_ok, a_ok;
  logic [VW-1:0] x_mag, y_mag;
  logic [VW:0]   trial;
  logic [VW-1:0] cmask;
  logic [31:0]   mul_x, mul_y;
  logic [63:0]   mul_p;

  always_comb begin
    x_ok  = tag_b == trbe_pkg::TAG_S64;
    y_ok  = tag_c == trbe_pkg::TAG_S64;
    a_ok  = tag_a == trbe_pkg::TAG_S64;
    x_mag = val_b[VW-1] ? (~val_b + 64'd1) : val_b;
    y_mag = val_c[VW-1] ? (~val_c + 64'd1) : val_c;
    trial = {rem, quo[VW-1]} - {1'b0, dvs};
    case (op) inside
      trbe_pkg::OP_I8, trbe_pkg::OP_U8:   cmask = 64'h0000_0000_0000_00FF;
      trbe_pkg::OP_I16, trbe_pkg::OP_U16: cmask = 64'h0000_0000_0000_FFFF;
      trbe_pkg::OP_I64, trbe_pkg::OP_U64: cmask = '1;
      default:                            cmask = 64'h0000_0000_FFFF_FFFF;
    endcase
    // Partial product cnt: 0 = lo*lo, 1 = lo*hi, 2 = hi*lo.
    mul_x = (cnt[1:0] == 2'd2) ? val_b[63:32] : val_b[31:0];
    mul_y = (cnt[1:0] == 2'd1) ? val_c[63:32] : val_c[31:0];
    mul_p = mul_x * mul_y;
  end

  always_comb begin
    r_step_next = 16'd1;
    r_halt_next = 1'b0;
    r_we_next   = 1'b0;
    r_type_next = '0;
    r_val_next  = '0;
    r_mis_next  = 1'b0;
    r_dz_next   = 1'b0;
    if (op <= trbe_pkg::OP_U64) begin
      r_we_next = 1'b1; r_type_next = op[TW-1:0]; r_val_next = imm & cmask;
    end else if (op <= trbe_pkg::OP_INV) begin
      if (!x_ok) r_mis_next = 1'b1;
      else begin
        r_we_next = 1'b1; r_type_next = trbe_pkg::TAG_S64;
        case (op)
          trbe_pkg::OP_NEG: r_val_next = 64'd0 - val_b;
          trbe_pkg::OP_POS: r_val_next = val_b;
          trbe_pkg::OP_NOT: r_val_next = {63'd0, val_b == '0};
          default:          r_val_next = ~val_b;
        endcase
      end
    end else if (op <= trbe_pkg::OP_NE) begin
      if (!x_ok || !y_ok) r_mis_next = 1'b1;
      else if ((op == trbe_pkg::OP_DIV || op == trbe_pkg::OP_MOD)
               && val_c == '0) r_dz_next = 1'b1;
      else begin
        r_we_next = 1'b1; r_type_next = trbe_pkg::TAG_S64;
        case (op) inside
          trbe_pkg::OP_ADD: r_val_next = val_b + val_c;
          trbe_pkg::OP_SUB: r_val_next = val_b - val_c;
          trbe_pkg::OP_AND: r_val_next = val_b & val_c;
          trbe_pkg::OP_OR:  r_val_next = val_b | val_c;
          trbe_pkg::OP_XOR: r_val_next = val_b ^ val_c;
          trbe_pkg::OP_SHL: r_val_next = val_b << val_c[5:0];
          trbe_pkg::OP_SHR: r_val_next = $unsigned($signed(val_b) >>> val_c[5:0]);
          // The iterative unit fills in the value later.
          trbe_pkg::OP_MUL, trbe_pkg::OP_DIV, trbe_pkg::OP_MOD: r_val_next = '0;
          default: r_val_next = {63'd0,
            trbe_pkg::compare_op(3'(op - trbe_pkg::OP_LT), val_b, val_c)};
        endcase
      end
    end else if (op <= trbe_pkg::OP_JNE) begin
      if (!a_ok || !x_ok) r_mis_next = 1'b1;
      else if (!trbe_pkg::compare_op(3'(op - trbe_pkg::OP_JLT), val_a, val_b))
        r_step_next = jump_dist;
    end else if (op == trbe_pkg::OP_MOV) begin
      r_we_next = 1'b1; r_type_next = tag_b; r_val_next = val_b;
    end else if (op == trbe_pkg::OP_JMP) begin
      r_step_next = jump_dist;
    end else if (op == trbe_pkg::OP_END) begin
      r_step_next = '0; r_halt_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= trbe_pkg::ST_IDLE;
      clearing <= 1'b1;
      clr_cnt  <= '0;
    end else begin
      if (clearing) begin
        clr_cnt <= clr_cnt + 1'b1;
        if (clr_cnt == (AW+1)'(trbe_pkg::NUM_REGS - 1)) clearing <= 1'b0;
      end
      unique case (state)
        trbe_pkg::ST_IDLE: begin
          if (s_axis_tvalid && s_axis_tready) state <= trbe_pkg::ST_READ;
        end
        trbe_pkg::ST_READ: state <= trbe_pkg::ST_EXEC;
        trbe_pkg::ST_EXEC: begin
          if (op == trbe_pkg::OP_MUL && x_ok && y_ok) state <= trbe_pkg::ST_MUL;
          else if ((op == trbe_pkg::OP_DIV || op == trbe_pkg::OP_MOD) && x_ok && y_ok
                   && val_c != '0) state <= trbe_pkg::ST_DIV;
          else state <= trbe_pkg::ST_OUT;
        end
        trbe_pkg::ST_MUL: begin
          if (cnt == 7'd2) state <= trbe_pkg::ST_OUT;
        end
        trbe_pkg::ST_DIV: begin
          if (cnt == 7'd63) state <= trbe_pkg::ST_DFIX;
        end
        trbe_pkg::ST_DFIX: state <= trbe_pkg::ST_OUT;
        trbe_pkg::ST_OUT: begin
          if (m_axis_tready) state <= trbe_pkg::ST_IDLE;
        end
        default: state <= trbe_pkg::ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      trbe_pkg::ST_IDLE: begin
        op        <= s_axis_tdata[5:0];
        ra        <= s_axis_tdata[10:6];
        rb        <= s_axis_tdata[15:11];
        rc        <= s_axis_tdata[20:16];
        imm       <= s_axis_tdata[84:21];
        jump_dist <= s_axis_tdata[100:85];
      end
      trbe_pkg::ST_EXEC: begin
        r_step <= r_step_next;
        r_halt <= r_halt_next;
        r_we   <= r_we_next;
        r_type <= r_type_next;
        r_val  <= r_val_next;
        r_mis  <= r_mis_next;
        r_dz   <= r_dz_next;
        cnt    <= '0;
        rem    <= '0;
        quo    <= x_mag;
        dvs    <= y_mag;
        neg_q  <= val_b[VW-1] ^ val_c[VW-1];
        neg_r  <= val_b[VW-1];
      end
      trbe_pkg::ST_MUL: begin
        cnt <= cnt + 7'd1;
        if (cnt == 7'd0) r_val <= mul_p;
        else r_val <= r_val + {mul_p[31:0], 32'd0};
      end
      trbe_pkg::ST_DIV: begin
        cnt <= cnt + 7'd1;
        if (!trial[VW]) begin
          rem <= trial[VW-1:0];
          quo <= {quo[VW-2:0], 1'b1};
        end else begin
          rem <= {rem[VW-2:0], quo[VW-1]};
          quo <= {quo[VW-2:0], 1'b0};
        end
      end
      trbe_pkg::ST_DFIX: begin
        if (op == trbe_pkg::OP_DIV) r_val <= neg_q ? (64'd0 - quo) : quo;
        else r_val <= neg_r ? (64'd0 - rem) : rem;
      end
      default: ;
    endcase
  end

endmodule
